@@ hw/rtl/evli_pkg.sv @@
`default_nettype none

package evli_pkg;

    // Q16.16 word and derived widths
    localparam int DATA_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int RATIO_W     = FRAC_W + 1;
    localparam int INDEX_W     = 16;
    localparam int NUM_FIELDS  = 4;
    localparam int NUM_SLOTS   = NUM_FIELDS + 1;
    localparam int ACT_W       = 3;
    localparam int CFG_IDX_W   = 8;

    localparam int S_TDATA_W   = 12 * DATA_W;
    localparam int M_FIELDS_W  = INDEX_W + RATIO_W + NUM_SLOTS * DATA_W;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    localparam int DEF_MAX_FIELDS = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CUT_X  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 8'd1;

    localparam logic [ACT_W-1:0]   ACTIVE_RESET = 3'd4;
    localparam logic [INDEX_W-1:0] COUNT_MAX    = 16'hFFFF;

    typedef logic signed [DATA_W-1:0] word_t;

endpackage

`default_nettype wire

@@ hw/rtl/edge_vertical_line_intersect.sv @@
`default_nettype none

// Channel   Dir  Width  Content
// s_*       in   384    edge: start_x, start_y, end_x, end_y, start_value0..3, end_value0..3
// m_*       out  200    crossing: point_index, ratio, cross_y, cross_value0..3
// cfg_*     in   8+32   register write: cut_x, active_functions (taken only while idle)
//
// A crossing reaches the output register through the crossing test, 17 bit-serial
// divider steps, 7 steps of the shared subtract/multiply/add chain and one transfer;
// the input is ready again only after that, so edges are not overlapped. An edge with
// no crossing frees the input after the crossing test. Reset is synchronous on aresetn.
// A result held by m_tready does not hold off the input; the next crossing then waits in
// the last step, with the input held off, until the output register frees.
module edge_vertical_line_intersect #(
    parameter int MAX_FIELDS = evli_pkg::DEF_MAX_FIELDS
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output      logic                            s_tready,
    // start_x, start_y, end_x, end_y, start_value0..3, end_value0..3 (low bit up)
    input  wire logic [evli_pkg::S_TDATA_W-1:0]  s_tdata,
    output      logic                            m_tvalid,
    input  wire logic                            m_tready,
    // point_index, ratio, cross_y, cross_value0..3, zero pad (low bit up)
    output      logic [evli_pkg::M_TDATA_W-1:0]  m_tdata,
    input  wire logic                            cfg_valid,
    output      logic                            cfg_ready,
    input  wire logic [evli_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [evli_pkg::DATA_W-1:0]     cfg_data
);
    import evli_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam int DIV_LAST = RATIO_W - 1;
    localparam int MUL_LAST = NUM_SLOTS + 1;
    localparam int PROD_W   = DATA_W + 1 + RATIO_W + 1;

    logic [2:0]          state_reg;
    logic [DATA_W-1:0]   cut_x_reg;
    logic [ACT_W-1:0]    active_reg;
    logic [INDEX_W-1:0]  count_reg;

    word_t               sx_reg, sy_reg, ex_reg, ey_reg;
    word_t               sv_reg [MAX_FIELDS];
    word_t               ev_reg [MAX_FIELDS];

    logic [DATA_W-1:0]   ad_reg;
    logic [DATA_W:0]     rem_reg;
    logic [RATIO_W-1:0]  q_reg;
    logic [4:0]          step_reg;
    logic [NUM_SLOTS-1:0] act_reg;

    logic signed [DATA_W:0]   diff_reg;
    word_t                    s1_reg, s2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    word_t                    res_reg [NUM_SLOTS];

    logic                out_valid_reg;
    logic [INDEX_W-1:0]  out_index_reg;
    logic [RATIO_W-1:0]  out_ratio_reg;
    word_t               out_val_reg [NUM_SLOTS];

    // crossing test
    logic signed [DATA_W:0] n_val, d_val;
    logic [DATA_W:0]        n_abs, d_abs;
    logic                   hit;
    logic [ACT_W-1:0]       nact;
    logic [NUM_SLOTS-1:0]   act_mask;

    // divider step
    logic [DATA_W:0]        rem_sh;
    logic                   q_bit;

    // multiply chain
    word_t                  op_s, op_e;
    logic signed [PROD_W-1:0] ratio_ext, diff_ext;
    logic signed [PROD_W-1:0] sum_val;
    logic [2:0]             slot;
    logic                   out_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign out_free  = !out_valid_reg || m_tready;

    always_comb begin
        n_val = $signed({cut_x_reg[DATA_W-1], cut_x_reg}) - $signed({sx_reg[DATA_W-1], sx_reg});
        d_val = $signed({ex_reg[DATA_W-1], ex_reg}) - $signed({sx_reg[DATA_W-1], sx_reg});
        n_abs = n_val[DATA_W] ? -n_val : n_val;
        d_abs = d_val[DATA_W] ? -d_val : d_val;
        if (d_val > 0) begin
            hit = (n_val >= 0) && (n_val <= d_val);
        end else if (d_val < 0) begin
            hit = (n_val <= 0) && (n_val >= d_val);
        end else begin
            hit = 1'b0;
        end
        // clamp the field count to what is built
        nact = (active_reg > ACT_W'(MAX_FIELDS)) ? ACT_W'(MAX_FIELDS) : active_reg;
        act_mask[0] = 1'b1;
        for (int k = 0; k < NUM_FIELDS; k++) begin
            act_mask[k+1] = (ACT_W'(k) < nact);
        end
    end

    always_comb begin
        rem_sh = (step_reg == 5'd0) ? rem_reg : {rem_reg[DATA_W-1:0], 1'b0};
        q_bit  = (rem_sh >= {1'b0, ad_reg});
    end

    always_comb begin
        op_s = sy_reg;
        op_e = ey_reg;
        for (int k = 0; k < MAX_FIELDS; k++) begin
            if (step_reg == 5'(k + 1)) begin
                op_s = sv_reg[k];
                op_e = ev_reg[k];
            end
        end
        ratio_ext = {{(PROD_W-RATIO_W){1'b0}}, q_reg};
        diff_ext  = {{(PROD_W-DATA_W-1){diff_reg[DATA_W]}}, diff_reg};
        // v = s*65536 + ratio*(e-s); floor shift is a plain bit select
        sum_val = prod_reg + {{(PROD_W-DATA_W-FRAC_W){s2_reg[DATA_W-1]}}, s2_reg, {FRAC_W{1'b0}}};
        slot    = step_reg[2:0] - 3'd2;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cut_x_reg     <= '0;
            active_reg    <= ACTIVE_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_CUT_X) begin
                    cut_x_reg <= cfg_data;
                    count_reg <= '0;
                end else if (cfg_index == REG_ACTIVE) begin
                    active_reg <= cfg_data[ACT_W-1:0];
                    count_reg  <= '0;
                end
            end

            if ((state_reg == ST_DONE) && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    state_reg <= hit ? ST_DIV : ST_IDLE;
                end
                ST_DIV: begin
                    if (step_reg == 5'(DIV_LAST)) begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (step_reg == 5'(MUL_LAST)) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // hold until the output register frees up
                    if (out_free) begin
                        if (count_reg != COUNT_MAX) begin
                            count_reg <= count_reg + INDEX_W'(1);
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath, no reset
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    sx_reg <= s_tdata[0*DATA_W +: DATA_W];
                    sy_reg <= s_tdata[1*DATA_W +: DATA_W];
                    ex_reg <= s_tdata[2*DATA_W +: DATA_W];
                    ey_reg <= s_tdata[3*DATA_W +: DATA_W];
                    for (int k = 0; k < MAX_FIELDS; k++) begin
                        sv_reg[k] <= s_tdata[(4+k)*DATA_W +: DATA_W];
                        ev_reg[k] <= s_tdata[(8+k)*DATA_W +: DATA_W];
                    end
                end
            end
            ST_CHECK: begin
                rem_reg  <= n_abs;
                ad_reg   <= d_abs[DATA_W-1:0];
                act_reg  <= act_mask;
                step_reg <= '0;
            end
            ST_DIV: begin
                rem_reg  <= q_bit ? (rem_sh - {1'b0, ad_reg}) : rem_sh;
                q_reg    <= {q_reg[RATIO_W-2:0], q_bit};
                step_reg <= (step_reg == 5'(DIV_LAST)) ? 5'd0 : step_reg + 5'd1;
            end
            ST_MUL: begin
                // three-deep chain: subtract, multiply, add
                diff_reg <= $signed({op_e[DATA_W-1], op_e}) - $signed({op_s[DATA_W-1], op_s});
                s1_reg   <= op_s;
                prod_reg <= ratio_ext * diff_ext;
                s2_reg   <= s1_reg;
                if (step_reg >= 5'd2) begin
                    res_reg[slot] <= act_reg[slot] ? sum_val[DATA_W+FRAC_W-1:FRAC_W] : '0;
                end
                step_reg <= step_reg + 5'd1;
            end
            ST_DONE: begin
                if (out_free) begin
                    out_index_reg <= count_reg;
                    out_ratio_reg <= q_reg;
                    for (int k = 0; k < NUM_SLOTS; k++) begin
                        out_val_reg[k] <= res_reg[k];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_tdata = '0;
        m_tdata[INDEX_W-1:0]                 = out_index_reg;
        m_tdata[INDEX_W +: RATIO_W]          = out_ratio_reg;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            m_tdata[INDEX_W + RATIO_W + k*DATA_W +: DATA_W] = out_val_reg[k];
        end
    end

endmodule

`default_nettype wire

@@ bench/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import evli_pkg::*;

    localparam word_t  W_MIN = 32'sh8000_0000;
    localparam word_t  W_MAX = 32'sh7FFF_FFFF;
    localparam longint Q_ONE = 64'sd65536;

    // Register indexes outside the map: writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOP    = 8'hFF;

    localparam int Y_LSB   = INDEX_W + RATIO_W;
    localparam int VAL_LSB = Y_LSB + DATA_W;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        word_t sx;
        word_t sy;
        word_t ex;
        word_t ey;
        word_t sv[NUM_FIELDS];
        word_t ev[NUM_FIELDS];
    } mesh_edge_t;

    typedef struct {
        logic [INDEX_W-1:0] index;
        logic [RATIO_W-1:0] ratio;
        word_t              y;
        word_t              val[NUM_FIELDS];
    } crossing_t;

    class crossing_board;
        word_t              cut_x;
        logic [ACT_W-1:0]   nfields;
        logic [INDEX_W-1:0] count;
        crossing_t          expected[$];
        int                 errors;
        int                 seen;

        function new();
            cut_x   = '0;
            nfields = ACTIVE_RESET;
            count   = '0;
            errors  = 0;
            seen    = 0;
        endfunction

        function int pending();
            return expected.size();
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
            case (idx)
                REG_CUT_X: begin
                    cut_x = data;
                    count = '0;
                end
                REG_ACTIVE: begin
                    nfields = data[ACT_W-1:0];
                    count   = '0;
                end
                default: ;
            endcase
        endfunction

        // floor((ratio*b + (1-ratio)*a)), exact in 64 bits
        function word_t interp(longint ratio, longint a, longint b);
            longint acc;
            acc = ratio * b + (Q_ONE - ratio) * a;
            acc = acc >>> FRAC_W;
            return acc[DATA_W-1:0];
        endfunction

        function void note_edge(mesh_edge_t e);
            longint    cx, sx, ex, n, d, an, ad, r;
            bit        hit;
            int        nf;
            int        k;
            crossing_t c;
            cx = cut_x;
            sx = e.sx;
            ex = e.ex;
            n  = cx - sx;
            d  = ex - sx;
            if (d > 0) begin
                hit = (n >= 0) && (n <= d);
            end else if (d < 0) begin
                hit = (n <= 0) && (n >= d);
            end else begin
                hit = 1'b0;
            end
            if (!hit) return;
            an = (n < 0) ? -n : n;
            ad = (d < 0) ? -d : d;
            r  = (an << FRAC_W) / ad;
            nf = (nfields > DEF_MAX_FIELDS) ? DEF_MAX_FIELDS : nfields;
            c.index = count;
            c.ratio = r[RATIO_W-1:0];
            c.y     = interp(r, e.sy, e.ey);
            for (k = 0; k < NUM_FIELDS; k++) begin
                c.val[k] = (k < nf) ? interp(r, e.sv[k], e.ev[k]) : '0;
            end
            expected.push_back(c);
            if (count != COUNT_MAX) count++;
        endfunction

        task report(string msg);
            $display("crossing check: %s", msg);
            errors++;
        endtask

        task compare_field(string name, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
            if (got !== want) begin
                report($sformatf("result %0d %s: got %h, want %h", seen, name, got, want));
            end
        endtask

        task check_crossing(logic [M_TDATA_W-1:0] data);
            crossing_t want;
            int        k;
            if (expected.size() == 0) begin
                report($sformatf("crossing with none pending: %h", data));
                return;
            end
            want = expected.pop_front();
            compare_field("point_index", data[0 +: INDEX_W], want.index);
            compare_field("ratio", data[INDEX_W +: RATIO_W], want.ratio);
            compare_field("cross_y", data[Y_LSB +: DATA_W], want.y);
            for (k = 0; k < NUM_FIELDS; k++) begin
                compare_field($sformatf("cross_value%0d", k),
                              data[VAL_LSB + k*DATA_W +: DATA_W], want.val[k]);
            end
            compare_field("pad", data[M_TDATA_W-1:M_FIELDS_W], '0);
            seen++;
        endtask

        task close_out();
            if (expected.size() != 0) begin
                report($sformatf("%0d crossings never came out", expected.size()));
            end
        endtask
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [DATA_W-1:0]      cfg_data;

    crossing_board board;
    int            hold_requests;

    edge_vertical_line_intersect u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic longint rand_between(longint lo, longint hi);
        longint unsigned r;
        longint unsigned span;
        span = hi - lo + 1;
        r    = {$urandom, $urandom};
        return lo + longint'(r % span);
    endfunction

    function automatic word_t rand_word();
        case ($urandom_range(0, 19))
            0:       return W_MIN;
            1:       return W_MAX;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic mesh_edge_t mk_edge(longint sx, longint ex);
        mesh_edge_t e;
        int         k;
        e.sx = sx[DATA_W-1:0];
        e.ex = ex[DATA_W-1:0];
        e.sy = rand_word();
        e.ey = rand_word();
        for (k = 0; k < NUM_FIELDS; k++) begin
            e.sv[k] = rand_word();
            e.ev[k] = rand_word();
        end
        return e;
    endfunction

    function automatic mesh_edge_t gen_edge(longint cut);
        longint span, lo, hi, a, b, t;
        int     kind;
        kind = $urandom_range(0, 99);
        span = longint'(1) << $urandom_range(0, 32);
        lo   = (cut - span < W_MIN) ? W_MIN : cut - span;
        hi   = (cut + span > W_MAX) ? W_MAX : cut + span;
        if (kind < 65) begin
            a = rand_between(lo, cut);
            b = rand_between(cut, hi);
            case ($urandom_range(0, 9))
                0:       a = cut;
                1:       b = cut;
                default: ;
            endcase
            if ($urandom_range(0, 1)) begin
                t = a;
                a = b;
                b = t;
            end
        end else if (kind < 75) begin
            a = ($urandom_range(0, 2) == 0) ? cut : rand_between(W_MIN, W_MAX);
            b = a;
        end else if (kind < 88) begin
            // both ends on one side, often just off the line
            if (cut == W_MIN || (cut != W_MAX && $urandom_range(0, 1))) begin
                a = rand_between(cut + 1, hi);
                b = rand_between(cut + 1, hi);
            end else begin
                a = rand_between(lo, cut - 1);
                b = rand_between(lo, cut - 1);
            end
        end else begin
            a = rand_between(W_MIN, W_MAX);
            b = rand_between(W_MIN, W_MAX);
        end
        return mk_edge(a, b);
    endfunction

    task automatic send_edge(mesh_edge_t e);
        logic [S_TDATA_W-1:0] bus;
        int                   k;
        bus = '0;
        bus[0*DATA_W +: DATA_W] = e.sx;
        bus[1*DATA_W +: DATA_W] = e.sy;
        bus[2*DATA_W +: DATA_W] = e.ex;
        bus[3*DATA_W +: DATA_W] = e.ey;
        for (k = 0; k < NUM_FIELDS; k++) begin
            bus[(4 + k)*DATA_W +: DATA_W] = e.sv[k];
            bus[(8 + k)*DATA_W +: DATA_W] = e.ev[k];
        end
        s_tdata  <= bus;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_edge(e);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.apply_reg(idx, data);
    endtask

    task automatic wait_drain();
        while (board.pending() != 0) @(posedge aclk);
    endtask

    // a missed edge leaves no result behind, so give it time to clear
    task automatic settle();
        wait_drain();
        repeat (32) @(posedge aclk);
    endtask

    task automatic write_config(word_t cut, logic [ACT_W-1:0] act);
        logic [DATA_W-1:0] act_word;
        settle();
        act_word = $urandom;
        act_word[ACT_W-1:0] = act;
        if ($urandom_range(0, 1)) begin
            write_reg(REG_CUT_X, cut);
            write_reg(REG_ACTIVE, act_word);
        end else begin
            write_reg(REG_ACTIVE, act_word);
            write_reg(REG_CUT_X, cut);
        end
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic run_phase(int items, bit gaps, bit hits_only,
                             int hold_at, int pause_at, int probe_at);
        mesh_edge_t e;
        longint     cut;
        int         i;
        int         burst;
        int         gap;
        burst = $urandom_range(1, 20);
        for (i = 0; i < items; i++) begin
            if (i == hold_at) hold_requests <= hold_requests + 1;
            if (i == pause_at) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                wait_drain();
            end
            if (i == probe_at) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                settle();
                write_reg(REG_UNUSED, $urandom);
                write_reg(REG_TOP, $urandom);
                cfg_valid <= 1'b0;
                @(posedge aclk);
            end
            cut = board.cut_x;
            if (hits_only) begin
                e = mk_edge(cut - longint'($urandom_range(1, 1 << 20)),
                            cut + longint'($urandom_range(0, 1 << 20)));
            end else begin
                e = gen_edge(cut);
            end
            send_edge(e);
            burst--;
            if (burst == 0) begin
                burst = $urandom_range(1, 20);
                if (gaps) begin
                    gap = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
        s_tvalid <= 1'b0;
    endtask

    // result side: stall pattern is drawn anew when each random-length run ends
    initial begin
        int mode;
        int mode_left;
        int hold_left;
        int hold_seen;
        int period;
        m_tready  = 1'b0;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        hold_seen = 0;
        period    = 2;
        forever begin
            @(posedge aclk);
            if (hold_requests != hold_seen) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(50, 300);
                period    = $urandom_range(2, 6);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= $urandom_range(0, 1);
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (mode_left % period == 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_crossing(m_tdata);
    end

    initial begin
        #5_000_000;
        $display("edge_vertical_line_intersect: mismatch");
        $finish;
    end

    initial begin
        mesh_edge_t directed_q[$];
        mesh_edge_t e;
        int         k;
        board         = new();
        hold_requests = 0;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: line at x = 0, all four fields active
        directed_q.push_back(mk_edge(-65536, 65536));
        directed_q.push_back(mk_edge(0, 1000));        // start node on the line
        directed_q.push_back(mk_edge(-1000, 0));       // end node on the line
        directed_q.push_back(mk_edge(65536, -65536));  // right to left
        directed_q.push_back(mk_edge(0, 0));           // vertical edge on the line
        directed_q.push_back(mk_edge(12345, 12345));
        directed_q.push_back(mk_edge(1, 50000));       // just short of the start
        directed_q.push_back(mk_edge(-50000, -1));     // just past the end
        directed_q.push_back(mk_edge(W_MIN, W_MAX));
        directed_q.push_back(mk_edge(W_MAX, W_MIN));
        directed_q.push_back(mk_edge(W_MIN, 1));
        directed_q.push_back(mk_edge(-1, W_MAX));
        directed_q.push_back(mk_edge(W_MIN, W_MIN));
        directed_q.push_back(mk_edge(W_MAX, 0));
        directed_q.push_back(mk_edge(3, -7));
        e = mk_edge(-3, 5);
        e.sy = W_MAX;
        e.ey = W_MIN;
        for (k = 0; k < NUM_FIELDS; k++) begin
            e.sv[k] = W_MIN;
            e.ev[k] = W_MAX;
        end
        directed_q.push_back(e);
        e = mk_edge(W_MIN, W_MAX);
        e.sy = W_MIN;
        e.ey = W_MAX;
        for (k = 0; k < NUM_FIELDS; k++) begin
            e.sv[k] = W_MAX;
            e.ev[k] = W_MIN;
        end
        directed_q.push_back(e);
        foreach (directed_q[i]) send_edge(directed_q[i]);
        s_tvalid <= 1'b0;

        write_config(W_MIN, 3'd0);
        run_phase(150, 1'b1, 1'b0, -1, -1, -1);
        write_config(W_MAX, 3'd1);
        run_phase(150, 1'b1, 1'b0, -1, -1, -1);
        write_config($urandom, 3'd2);
        run_phase(150, 1'b1, 1'b0, -1, -1, 60);
        // sender never idles here, so the long hold backs up the input
        write_config(DATA_W'(rand_between(-(1 << 20), 1 << 20)), 3'd3);
        run_phase(150, 1'b0, 1'b0, 40, -1, -1);
        write_config($urandom, 3'd5);
        run_phase(150, 1'b1, 1'b0, -1, -1, -1);
        write_config($urandom, 3'd7);
        run_phase(150, 1'b1, 1'b0, -1, -1, -1);
        write_config('1, 3'd4);
        run_phase(150, 1'b1, 1'b0, -1, 70, -1);
        // every edge crosses x = 0, so the point index climbs by one per item
        write_config('0, 3'd4);
        run_phase(50, 1'b0, 1'b1, -1, -1, -1);
        write_config($urandom, 3'd4);
        run_phase(150, 1'b1, 1'b0, -1, -1, -1);

        wait_drain();
        repeat (40) @(posedge aclk);
        board.close_out();
        if (board.errors == 0) begin
            $display("edge_vertical_line_intersect: match");
        end else begin
            $display("edge_vertical_line_intersect: mismatch");
        end
        $finish;
    end

endmodule

@@ edge_vertical_line_intersect.f @@
hw/rtl/evli_pkg.sv
hw/rtl/edge_vertical_line_intersect.sv
bench/tb.sv
